// File: rtl/core/pts_pkg.sv
package pts_pkg;

	localparam int Channels = 32;
	localparam int ChW = 5;
	localparam int ValW = 34;
	localparam int SumW = 64;
	localparam int ClkW = 27;
	localparam logic [ClkW-1:0] ClkReset = 27'd40000000;
	localparam logic [ValW-1:0] Max34 = {ValW{1'b1}};

	typedef enum logic [2:0] {
		Q_PERIOD = 3'd0,
		Q_FREQ   = 3'd1,
		Q_DUTY   = 3'd2,
		Q_PHASE  = 3'd3,
		Q_ZPHASE = 3'd4
	} quantity_t;

	typedef struct packed {
		logic        func;
		logic [4:0]  channel;
		logic [31:0] timestamp_word;
	} in_word_t;

	typedef struct packed {
		logic [4:0]      out_channel;
		logic [2:0]      quantity;
		logic [ValW-1:0] latest;
		logic [ValW-1:0] minimum;
		logic [ValW-1:0] maximum;
		logic [ValW-1:0] mean;
		logic            last_of_run;
	} out_word_t;

	// front -> back job; clr rides the same queue so it lands in order
	typedef struct packed {
		logic        clr;
		logic        zph;
		logic [4:0]  ch;
		logic [30:0] zval;
		logic [30:0] period;
		logic [30:0] high;
	} job_t;

endpackage

// File: rtl/core/pulse_timing_statistics_unit.sv
// Pulse timing statistics for 32 channels. An edge word with edge count 1..3
// yields one Z-phase result; each even edge from 4 yields four results
// (period, frequency, duty, phase), computed with the shared 64-step restoring
// divider run six times. Odd edges from 5 give no result; a clear word queues
// behind the pending job so it takes effect in order. The front holds one
// pending job, so the next word is taken while the back works, but every word
// waits while that job is still pending.
module pulse_timing_statistics_unit import pts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  in_word,
	input  logic      cfg_we,
	input  logic [ClkW-1:0] cfg_wdata,
	output logic      empty,
	input  logic      pop,
	output out_word_t out_word
);
	logic [ClkW-1:0] clk_hz_q;
	logic            job_valid, job_ready;
	job_t            job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clk_hz_q <= ClkReset;
		else if (cfg_we) clk_hz_q <= cfg_wdata;
	end

	pts_front u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.job_valid, .job_ready, .job
	);

	pts_back u_back (
		.clk, .arst_n, .clk_hz(clk_hz_q),
		.job_valid, .job_ready, .job, .empty, .pop, .rd_data(out_word)
	);
endmodule

// File: rtl/core/pts_divider.sv
// restoring divider, one quotient bit per cycle
module pts_divider import pts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [30:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [31:0] trial;

	assign trial = {rem_q[30:0], quo_q[63]} - {1'b0, div_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[31]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/core/pts_front.sv
// per-channel edge tracking; emits jobs for the back end
module pts_front import pts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t in_word,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);
	logic [15:0] cnt_q [Channels];
	logic [31:0] first_q [Channels];
	logic [31:0] start_q [Channels];
	logic [31:0] mid_q [Channels];
	logic [31:0] end_q [Channels];
	logic [30:0] z_q [Channels];

	logic [4:0]  ch;
	logic [15:0] n;
	logic [30:0] t, ts, tm;
	logic        lvl, acc, emit_job;

	assign ch = in_word.channel;
	assign t = in_word.timestamp_word[30:0];
	assign lvl = in_word.timestamp_word[31];
	assign ts = start_q[ch][30:0];
	assign tm = mid_q[ch][30:0];
	assign n = (cnt_q[ch] == 16'hffff) ? cnt_q[ch] : cnt_q[ch] + 16'd1;
	assign full = job_valid && !job_ready;
	assign acc = push && !full;
	// odd edges from 5 on stay in the front
	assign emit_job = acc && (in_word.func || (n < 16'd4) || !n[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
			for (int i = 0; i < Channels; i++) begin
				cnt_q[i] <= '0;
				first_q[i] <= '0;
				start_q[i] <= '0;
				mid_q[i] <= '0;
				end_q[i] <= '0;
				z_q[i] <= '0;
			end
		end else begin
			job_valid <= emit_job || (job_valid && !job_ready);
			if (acc && in_word.func) begin
				cnt_q[ch] <= '0;
				first_q[ch] <= '0;
				start_q[ch] <= '0;
				mid_q[ch] <= '0;
				end_q[ch] <= '0;
				z_q[ch] <= '0;
				job.clr <= 1'b1;
				job.ch <= ch;
			end else if (acc) begin
				cnt_q[ch] <= n;
				job.clr <= 1'b0;
				job.ch <= ch;
				job.period <= t - ts;
				job.high <= lvl ? t - tm : tm - ts;
				if (n == 16'd1) begin
					first_q[ch] <= in_word.timestamp_word;
					if (!lvl && t != 31'd1) z_q[ch] <= t;
					job.zph <= 1'b1;
					job.zval <= (!lvl && t != 31'd1) ? t : z_q[ch];
				end else if (n == 16'd2) begin
					start_q[ch] <= in_word.timestamp_word;
					if (!lvl) z_q[ch] <= t;
					job.zph <= 1'b1;
					job.zval <= !lvl ? t : z_q[ch];
				end else if (n == 16'd3) begin
					mid_q[ch] <= in_word.timestamp_word;
					if (!lvl && first_q[ch][30:0] == 31'd1) z_q[ch] <= t;
					job.zph <= 1'b1;
					job.zval <= (!lvl && first_q[ch][30:0] == 31'd1) ? t : z_q[ch];
				end else if (!n[0]) begin
					end_q[ch] <= in_word.timestamp_word;
					job.zph <= 1'b0;
					job.zval <= z_q[ch];
				end else begin
					start_q[ch] <= end_q[ch];
					mid_q[ch] <= in_word.timestamp_word;
				end
			end
		end
	end
endmodule

// File: rtl/core/pts_back.sv
// statistics engine: divides, updates per-channel stats, emits results
module pts_back import pts_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [ClkW-1:0] clk_hz,
	input  logic            job_valid,
	output logic            job_ready,
	input  job_t            job,
	output logic            empty,
	input  logic            pop,
	output out_word_t       rd_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_FREQ, S_FWAIT, S_DUTY, S_DWAIT, S_UPD, S_MEAN, S_MWAIT, S_EMIT
	} state_t;

	typedef struct packed {
		logic [ValW-1:0] mn;
		logic [ValW-1:0] mx;
		logic [SumW-1:0] sum;
	} stat_t;

	state_t      state_q;
	job_t        job_q;
	// one entry per channel holding the four quantities
	stat_t [3:0] st_q [Channels];
	logic [15:0] pc_q [Channels];
	logic [ValW-1:0] val_q [4];
	logic [ValW-1:0] mean_q [4];
	logic [1:0]  k_q;
	logic [2:0]  nout_q;
	out_word_t   ow_q;
	logic        full_q;

	logic        dstart, ddone;
	logic [63:0] dend, dquo;
	logic [30:0] dsor;
	logic [44:0] mul_q;

	pts_divider u_div (
		.clk, .arst_n, .start(dstart), .dividend(dend), .divisor(dsor),
		.done(ddone), .quotient(dquo)
	);

	assign job_ready = (state_q == S_IDLE);
	assign empty = !full_q;
	assign rd_data = ow_q;

	always_comb begin
		dstart = 1'b0;
		dend = '0;
		dsor = job_q.period;
		unique case (state_q)
			S_FREQ: begin
				dstart = 1'b1;
				dend = {19'd0, mul_q};
			end
			S_DUTY: begin
				dstart = 1'b1;
				dend = {19'd0, mul_q};
			end
			S_MEAN: begin
				dstart = 1'b1;
				dend = st_q[job_q.ch][k_q].sum;
				dsor = {15'd0, pc_q[job_q.ch]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q <= 1'b0;
			for (int c = 0; c < Channels; c++) begin
				pc_q[c] <= '0;
				for (int q = 0; q < 4; q++) begin
					st_q[c][q].mn <= (q == 2) ? ValW'(16'hffff) : Max34;
					st_q[c][q].mx <= '0;
					st_q[c][q].sum <= '0;
				end
			end
		end else begin
			// S_EMIT refills the output word itself
			if (pop && full_q && state_q != S_EMIT) full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (job_valid) begin
					job_q <= job;
					mul_q <= 45'(clk_hz) * 45'd100;
					k_q <= '0;
					if (job.clr) begin
						pc_q[job.ch] <= '0;
						for (int q = 0; q < 4; q++) begin
							st_q[job.ch][q].mn <= (q == 2) ? ValW'(16'hffff) : Max34;
							st_q[job.ch][q].mx <= '0;
							st_q[job.ch][q].sum <= '0;
						end
					end else if (job.zph) begin
						nout_q <= 3'd4;
						state_q <= S_EMIT;
					end else begin
						nout_q <= 3'd0;
						state_q <= S_FREQ;
					end
				end
				S_FREQ: begin
					state_q <= S_FWAIT;
					mul_q <= 45'(job_q.high) * 45'd10000;
				end
				S_FWAIT: if (ddone) begin
					val_q[1] <= (job_q.period == '0) ? Max34 : dquo[ValW-1:0];
					state_q <= S_DUTY;
				end
				S_DUTY: state_q <= S_DWAIT;
				S_DWAIT: if (ddone) begin
					val_q[0] <= ValW'(job_q.period);
					val_q[3] <= ValW'(job_q.high);
					val_q[2] <= (job_q.period == '0) ? '0 :
						(dquo > 64'hffff) ? ValW'(16'hffff) : dquo[ValW-1:0];
					state_q <= S_UPD;
				end
				S_UPD: begin
					for (int q = 0; q < 4; q++) begin
						if (val_q[q] < st_q[job_q.ch][q].mn) st_q[job_q.ch][q].mn <= val_q[q];
						if (val_q[q] > st_q[job_q.ch][q].mx) st_q[job_q.ch][q].mx <= val_q[q];
						st_q[job_q.ch][q].sum <= st_q[job_q.ch][q].sum + SumW'(val_q[q]);
					end
					if (pc_q[job_q.ch] != 16'hffff) pc_q[job_q.ch] <= pc_q[job_q.ch] + 16'd1;
					state_q <= S_MEAN;
				end
				S_MEAN: state_q <= S_MWAIT;
				S_MWAIT: if (ddone) begin
					mean_q[k_q] <= dquo[ValW-1:0];
					k_q <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? S_EMIT : S_MEAN;
				end
				S_EMIT: if (!full_q || pop) begin
					full_q <= 1'b1;
					ow_q.out_channel <= job_q.ch;
					if (nout_q == 3'd4) begin
						ow_q.quantity <= Q_ZPHASE;
						ow_q.latest <= ValW'(job_q.zval);
						ow_q.minimum <= '0;
						ow_q.maximum <= '0;
						ow_q.mean <= '0;
						ow_q.last_of_run <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ow_q.quantity <= nout_q;
						ow_q.latest <= val_q[nout_q[1:0]];
						ow_q.minimum <= st_q[job_q.ch][nout_q[1:0]].mn;
						ow_q.maximum <= st_q[job_q.ch][nout_q[1:0]].mx;
						ow_q.mean <= mean_q[nout_q[1:0]];
						ow_q.last_of_run <= (nout_q == 3'd3);
						nout_q <= nout_q + 3'd1;
						if (nout_q == 3'd3) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && full_q && state_q != S_EMIT) |=> !full_q) else $error("stale word");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> state_q == S_IDLE) else $error("ready while busy");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> (state_q == S_FWAIT || state_q == S_DWAIT || state_q == S_MWAIT))
		else $error("divider done unexpected");
endmodule
